@@ rtl/fqs_pkg.sv @@
// Shared types, codes and field widths for the FIFO queue with search.
`timescale 1ns / 1ps

package fqs_pkg;

   localparam int FQS_DEPTH_DEF     = 16;
   localparam int FQS_DATA_BITS_DEF = 8;

   localparam int FQS_TYPE_W   = 3;
   localparam int FQS_VALUE_W  = 8;
   localparam int FQS_STATUS_W = 2;
   localparam int FQS_DATA_W   = 8;
   localparam int FQS_POS_W    = 4;
   localparam int FQS_COUNT_W  = 5;
   localparam int FQS_LIMIT_W  = 5;

   localparam logic [FQS_LIMIT_W-1:0] FQS_LIMIT_RESET = 5'd16;

   typedef enum logic [FQS_TYPE_W-1:0] {
      REQ_ENQUEUE = 3'd0,
      REQ_DEQUEUE = 3'd1,
      REQ_PEEK    = 3'd2,
      REQ_SEARCH  = 3'd3,
      REQ_CLEAR   = 3'd4
   } req_code_type;

   typedef enum logic [FQS_STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_code_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_READ = 5'b00100,
      S_SCAN = 5'b01000,
      S_POST = 5'b10000
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic            take_req;
      logic            write_entry;
      logic            read_front;
      logic            read_next;
      logic            scan_clear;
      logic            scan_advance;
      logic            advance_front;
      logic            clear_queue;
      logic            load_result;
      status_code_type result_status;
      logic            result_data;
      logic            result_pos;
      logic            publish;
   } fqs_cmd_type;

   // Datapath to controller
   typedef struct packed {
      req_code_type req_code;
      logic         empty;
      logic         full;
      logic         match;
      logic         last;
      logic         out_free;
   } fqs_sts_type;

endpackage

@@ rtl/fqs_datapath.sv @@
// Datapath: entry store, pointers, count, limit register and result registers.
`timescale 1ns / 1ps

module fqs_datapath import fqs_pkg::*; #(
   parameter int DEPTH     = FQS_DEPTH_DEF,
   parameter int DATA_BITS = FQS_DATA_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [FQS_TYPE_W-1:0]    req_type,
   input  logic [FQS_VALUE_W-1:0]   req_item_value,
   input  logic                     csr_write_enable,
   input  logic [FQS_LIMIT_W-1:0]   csr_write_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [FQS_STATUS_W-1:0]  rsp_status,
   output logic [FQS_DATA_W-1:0]    rsp_out_data,
   output logic [FQS_POS_W-1:0]     rsp_match_position,
   output logic [FQS_COUNT_W-1:0]   rsp_entry_count,
   input  fqs_cmd_type              cmd,
   output fqs_sts_type              sts
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int SUM_BITS = CNT_BITS + 1;
   localparam int VAL_WIDE = (DATA_BITS > FQS_VALUE_W) ? DATA_BITS : FQS_VALUE_W;
   localparam int RD_WIDE  = (DATA_BITS > FQS_DATA_W) ? DATA_BITS : FQS_DATA_W;
   localparam int POS_WIDE = (CNT_BITS > FQS_POS_W) ? CNT_BITS : FQS_POS_W;
   localparam int CNT_WIDE = (CNT_BITS > FQS_COUNT_W) ? CNT_BITS : FQS_COUNT_W;
   localparam int LIM_WIDE = (CNT_BITS > FQS_LIMIT_W) ? CNT_BITS : FQS_LIMIT_W;

   // Physical slot of a queue position; front + pos stays below twice the depth
   function automatic logic [PTR_BITS-1:0] slot_of(input logic [PTR_BITS-1:0] front,
                                                   input logic [CNT_BITS-1:0] pos);
      logic [SUM_BITS-1:0] sum;
      sum = SUM_BITS'(front) + SUM_BITS'(pos);
      if (sum >= SUM_BITS'(DEPTH)) begin
         sum = sum - SUM_BITS'(DEPTH);
      end
      return sum[PTR_BITS-1:0];
   endfunction

   logic [DATA_BITS-1:0]    entry_store [DEPTH];

   logic [PTR_BITS-1:0]     front_ff, front_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [CNT_BITS-1:0]     scan_idx_ff, scan_idx_in;
   logic [FQS_LIMIT_W-1:0]  limit_ff, limit_in;
   logic [FQS_TYPE_W-1:0]   req_type_ff;
   logic [DATA_BITS-1:0]    req_value_ff;
   logic [DATA_BITS-1:0]    rd_data_ff;
   status_code_type         res_status_ff;
   logic [FQS_DATA_W-1:0]   res_data_ff, res_data_in;
   logic [FQS_POS_W-1:0]    res_pos_ff, res_pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FQS_STATUS_W-1:0] rsp_status_ff;
   logic [FQS_DATA_W-1:0]   rsp_data_ff;
   logic [FQS_POS_W-1:0]    rsp_pos_ff;
   logic [FQS_COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [VAL_WIDE-1:0]     val_wide;
   logic [RD_WIDE-1:0]      rd_wide;
   logic [POS_WIDE-1:0]     pos_wide;
   logic [CNT_WIDE-1:0]     cnt_wide;
   logic [LIM_WIDE-1:0]     lim_raw, lim_eff, lim_count;
   logic [CNT_BITS-1:0]     scan_next;
   logic [PTR_BITS-1:0]     rd_addr, wr_addr;

   assign val_wide  = VAL_WIDE'(req_item_value);
   assign rd_wide   = RD_WIDE'(rd_data_ff);
   assign pos_wide  = POS_WIDE'(scan_idx_ff);
   assign cnt_wide  = CNT_WIDE'(count_ff);
   assign scan_next = scan_idx_ff + CNT_BITS'(1);
   assign rd_addr   = cmd.read_front ? front_ff : slot_of(front_ff, scan_next);
   assign wr_addr   = slot_of(front_ff, count_ff);

   // Clamp the limit into one to depth
   always_comb begin
      lim_raw   = LIM_WIDE'(limit_ff);
      lim_count = LIM_WIDE'(count_ff);
      lim_eff   = lim_raw;
      if (lim_raw == '0) begin
         lim_eff = LIM_WIDE'(1);
      end else if (lim_raw > LIM_WIDE'(DEPTH)) begin
         lim_eff = LIM_WIDE'(DEPTH);
      end
   end

   always_comb begin
      sts.req_code = req_code_type'(req_type_ff);
      sts.empty    = (count_ff == '0);
      sts.full     = (lim_count >= lim_eff);
      sts.match    = (rd_data_ff == req_value_ff);
      sts.last     = (scan_next == count_ff);
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (cmd.clear_queue) begin
         front_in = '0;
         count_in = '0;
      end else if (cmd.write_entry) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.advance_front) begin
         front_in = slot_of(front_ff, CNT_BITS'(1));
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.scan_clear) begin
         scan_idx_in = '0;
      end else if (cmd.scan_advance) begin
         scan_idx_in = scan_next;
      end
   end

   assign limit_in    = csr_write_enable ? csr_write_data : limit_ff;
   assign res_data_in = cmd.result_data ? rd_wide[FQS_DATA_W-1:0] : '0;
   assign res_pos_in  = cmd.result_pos ? pos_wide[FQS_POS_W-1:0] : '0;
   assign rsp_count_in = cnt_wide[FQS_COUNT_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         limit_ff     <= FQS_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      if (cmd.take_req) begin
         req_type_ff  <= req_type;
         req_value_ff <= val_wide[DATA_BITS-1:0];
      end
      if (cmd.load_result) begin
         res_status_ff <= cmd.result_status;
         res_data_ff   <= res_data_in;
         res_pos_ff    <= res_pos_in;
      end
      if (cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
         rsp_pos_ff    <= res_pos_ff;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   // Entry store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         entry_store[wr_addr] <= req_value_ff;
      end
      if (cmd.read_front || cmd.read_next) begin
         rd_data_ff <= entry_store[rd_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_data       = rsp_data_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule

@@ rtl/fqs_controller.sv @@
// Controller: sequences each request through execute, a read or scan where needed, and result.
`timescale 1ns / 1ps

module fqs_controller import fqs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  fqs_sts_type sts,
   output fqs_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_POST;
            unique case (sts.req_code)
               REQ_ENQUEUE: begin
                  cmd.load_result = 1'b1;
                  if (sts.full) begin
                     cmd.result_status = ST_FULL;
                  end else begin
                     cmd.write_entry   = 1'b1;
                     cmd.result_status = ST_OK;
                  end
               end
               REQ_DEQUEUE, REQ_PEEK: begin
                  if (sts.empty) begin
                     cmd.load_result   = 1'b1;
                     cmd.result_status = ST_EMPTY;
                  end else begin
                     cmd.read_front = 1'b1;
                     state_in       = S_READ;
                  end
               end
               REQ_SEARCH: begin
                  if (sts.empty) begin
                     cmd.load_result   = 1'b1;
                     cmd.result_status = ST_EMPTY;
                  end else begin
                     cmd.read_front = 1'b1;
                     cmd.scan_clear = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               REQ_CLEAR: begin
                  cmd.clear_queue   = 1'b1;
                  cmd.load_result   = 1'b1;
                  cmd.result_status = ST_OK;
               end
               default: begin
                  cmd.load_result   = 1'b1;
                  cmd.result_status = ST_OK;
               end
            endcase
         end
         S_READ: begin
            cmd.load_result   = 1'b1;
            cmd.result_status = ST_OK;
            cmd.result_data   = 1'b1;
            cmd.advance_front = (sts.req_code == REQ_DEQUEUE);
            state_in          = S_POST;
         end
         S_SCAN: begin
            // Compare the entry read last cycle while fetching the next one
            if (sts.match) begin
               cmd.load_result   = 1'b1;
               cmd.result_status = ST_OK;
               cmd.result_pos    = 1'b1;
               state_in          = S_POST;
            end else if (sts.last) begin
               cmd.load_result   = 1'b1;
               cmd.result_status = ST_NOT_FOUND;
               state_in          = S_POST;
            end else begin
               cmd.read_next    = 1'b1;
               cmd.scan_advance = 1'b1;
            end
         end
         S_POST: begin
            // Hold the result until the output register is free
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/fifo_queue_with_search_unit.sv @@
// Top level of the FIFO byte queue with search: controller plus datapath.
`timescale 1ns / 1ps

// A fixed-depth first-in first-out queue that answers every request item with
// exactly one result item (status and the count after the request). The block
// works on one item at a time. Enqueue, clear, refused and empty requests pass
// from the execute state straight to the result state, dequeue and peek first
// read the front entry, and a search compares entries until a match or the
// end of the queue, from one entry up to the held count. The serial scan
// follows from the single read port of the entry store, which the search
// walks one entry per cycle. The input is open again in the same cycle in which
// the result is first offered, and a result that is not yet taken does not stop
// the next item being accepted; it only holds that item's result back. The
// capacity limit register may be written at any time the block is idle.

module fifo_queue_with_search_unit import fqs_pkg::*; #(
   parameter int DEPTH     = FQS_DEPTH_DEF,
   parameter int DATA_BITS = FQS_DATA_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [FQS_TYPE_W-1:0]   req_type,
   input  logic [FQS_VALUE_W-1:0]  req_item_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [FQS_STATUS_W-1:0] rsp_status,
   output logic [FQS_DATA_W-1:0]   rsp_out_data,
   output logic [FQS_POS_W-1:0]    rsp_match_position,
   output logic [FQS_COUNT_W-1:0]  rsp_entry_count,
   input  logic                    csr_write_enable,
   input  logic [FQS_LIMIT_W-1:0]  csr_write_data
);

   fqs_cmd_type cmd;
   fqs_sts_type sts;

   fqs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fqs_datapath #(
      .DEPTH     (DEPTH),
      .DATA_BITS (DATA_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_type           (req_type),
      .req_item_value     (req_item_value),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_out_data       (rsp_out_data),
      .rsp_match_position (rsp_match_position),
      .rsp_entry_count    (rsp_entry_count),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

@@ rtl/fqs_checker.sv @@
// Port-level checks on the FIFO queue with search, bound to the top level.
`timescale 1ns / 1ps

module fqs_checker import fqs_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [FQS_STATUS_W-1:0] rsp_status,
   input logic [FQS_DATA_W-1:0]   rsp_out_data,
   input logic [FQS_POS_W-1:0]    rsp_match_position,
   input logic [FQS_COUNT_W-1:0]  rsp_entry_count
);

   // One item in flight: the input closes right after an acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again straight after an acceptance");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_out_data) && $stable(rsp_match_position) && $stable(rsp_entry_count))
      else $error("stalled result item changed");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
      rsp_entry_count == '0 && rsp_out_data == '0 && rsp_match_position == '0)
      else $error("empty result carries data or a count");

   a_refused_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND) |->
      rsp_out_data == '0 && rsp_match_position == '0)
      else $error("full or not found result carries data or a position");

endmodule

bind fifo_queue_with_search_unit fqs_checker u_fqs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_out_data       (rsp_out_data),
   .rsp_match_position (rsp_match_position),
   .rsp_entry_count    (rsp_entry_count)
);
